/* hdl/lge_pkg.sv */
// ----------------------------------------------------------------------------
// lge_pkg
// Shared constants, operation codes and controller/datapath types for the
// life generation engine.
// ----------------------------------------------------------------------------
package lge_pkg;

    // field widths of the item and the size register
    localparam int unsigned KIND_W = 2;
    localparam int unsigned POS_W  = 6;
    localparam int unsigned SIZE_W = 7;

    // largest size the register can hold, and its reset value
    localparam int unsigned     SIZE_MAX   = 127;
    localparam logic [SIZE_W-1:0] SIZE_RESET = 7'd64;

    // operation codes
    localparam logic [KIND_W-1:0] KIND_WRITE   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_READ    = 2'd1;
    localparam logic [KIND_W-1:0] KIND_ADVANCE = 2'd2;
    localparam logic [KIND_W-1:0] KIND_UNUSED  = 2'd3;

    // B3/S23 neighbor counts
    localparam logic [3:0] BORN_COUNT = 4'd3;
    localparam logic [3:0] KEEP_COUNT = 4'd2;

    // commands from the controller to the datapath
    typedef struct packed {
        logic clear_wr;  // clear one row during the post-reset pass
        logic accept;    // take the input item
        logic cell_op;   // finish a single-cell read or write
        logic adv_load;  // load the first row into the window
        logic adv_step;  // compute and write back one row
        logic finish;    // move the result into the output register
    } t_dp_cmd;

    // status from the datapath to the controller
    typedef struct packed {
        logic              in_valid;
        logic [KIND_W-1:0] in_kind;
        logic              size_zero;
        logic              clear_last;
        logic              adv_last;
        logic              out_free;
    } t_dp_status;

endpackage

/* hdl/lge_in_if.sv */
// ----------------------------------------------------------------------------
// lge_in_if
// Input item channel: operation code, cell address and write value.
// ----------------------------------------------------------------------------
interface lge_in_if;
    logic                         valid;
    logic                         ready;
    logic [lge_pkg::KIND_W-1:0]   kind;
    logic [lge_pkg::POS_W-1:0]    row;
    logic [lge_pkg::POS_W-1:0]    col;
    logic                         cell_value;

    modport source (output valid, kind, row, col, cell_value, input ready);
    modport sink   (input valid, kind, row, col, cell_value, output ready);
endinterface

/* hdl/lge_out_if.sv */
// ----------------------------------------------------------------------------
// lge_out_if
// Result item channel: read cell state and completion flag.
// ----------------------------------------------------------------------------
interface lge_out_if;
    logic valid;
    logic ready;
    logic cell_alive;
    logic done_res;

    modport source (output valid, cell_alive, done_res, input ready);
    modport sink   (input valid, cell_alive, done_res, output ready);
endinterface

/* hdl/lge_cfg_if.sv */
// ----------------------------------------------------------------------------
// lge_cfg_if
// Configuration write channel for the grid size register.
// ----------------------------------------------------------------------------
interface lge_cfg_if;
    logic                       valid;
    logic                       ready;
    logic [lge_pkg::SIZE_W-1:0] grid_size;

    modport source (output valid, grid_size, input ready);
    modport sink   (input valid, grid_size, output ready);
endinterface

/* hdl/lge_ram.sv */
// ----------------------------------------------------------------------------
// lge_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module lge_ram #(
    parameter int unsigned WIDTH = 64,
    parameter int unsigned DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_data;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        r_rd_data <= mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;
endmodule

/* hdl/lge_ctrl.sv */
// ----------------------------------------------------------------------------
// lge_ctrl
// Sequencer: post-reset clearing pass, item intake, single-cell access and
// the row-by-row generation sweep.
// ----------------------------------------------------------------------------
module lge_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  lge_pkg::t_dp_status i_status,
    output lge_pkg::t_dp_cmd    o_cmd,
    output logic                o_in_ready
);
    import lge_pkg::*;

    localparam logic [2:0] S_CLEAR    = 3'd0;
    localparam logic [2:0] S_IDLE     = 3'd1;
    localparam logic [2:0] S_CELL     = 3'd2;
    localparam logic [2:0] S_ADV_LOAD = 3'd3;
    localparam logic [2:0] S_ADV_RUN  = 3'd4;
    localparam logic [2:0] S_FINISH   = 3'd5;

    logic [2:0] r_state;
    logic [2:0] n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and commands
    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clear_wr = 1'b1;
                if (i_status.clear_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_status.in_valid) begin
                    o_cmd.accept = 1'b1;
                    unique case (i_status.in_kind) inside
                        KIND_WRITE, KIND_READ: begin
                            n_state = S_CELL;
                        end
                        KIND_ADVANCE: begin
                            n_state = i_status.size_zero ? S_FINISH : S_ADV_LOAD;
                        end
                        default: begin
                            n_state = S_FINISH;
                        end
                    endcase
                end
            end
            S_CELL: begin
                o_cmd.cell_op = 1'b1;
                n_state       = S_FINISH;
            end
            S_ADV_LOAD: begin
                o_cmd.adv_load = 1'b1;
                n_state        = S_ADV_RUN;
            end
            S_ADV_RUN: begin
                o_cmd.adv_step = 1'b1;
                if (i_status.adv_last) begin
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                if (i_status.out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end
endmodule

/* hdl/lge_dp.sv */
// ----------------------------------------------------------------------------
// lge_dp
// Datapath: row-word cell store, three-row window, per-column neighbor
// count lanes, size register and the output register.
// ----------------------------------------------------------------------------
module lge_dp #(
    parameter int unsigned GRID_MAX = 64
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  lge_pkg::t_dp_cmd           i_cmd,
    output lge_pkg::t_dp_status        o_status,
    input  logic                       i_in_valid,
    input  logic [lge_pkg::KIND_W-1:0] i_kind,
    input  logic [lge_pkg::POS_W-1:0]  i_row,
    input  logic [lge_pkg::POS_W-1:0]  i_col,
    input  logic                       i_cell_value,
    input  logic                       i_cfg_valid,
    input  logic [lge_pkg::SIZE_W-1:0] i_cfg_grid_size,
    input  logic                       i_out_ready,
    output logic                       o_out_valid,
    output logic                       o_cell_alive,
    output logic                       o_done_res
);
    import lge_pkg::*;

    localparam int unsigned AW   = $clog2(GRID_MAX);
    localparam int unsigned RW   = (AW > SIZE_W) ? AW : SIZE_W;
    localparam int unsigned NCAP = (GRID_MAX < SIZE_MAX) ? GRID_MAX : SIZE_MAX;

    logic [SIZE_W-1:0]   r_grid_size;
    logic [SIZE_W-1:0]   w_size;
    logic [RW-1:0]       r_row;
    logic [RW:0]         row_plus1;
    logic [RW:0]         row_plus2;
    logic [RW:0]         size_ext;
    logic                next_in_use;
    logic                in_inside;
    logic [AW-1:0]       in_row_idx;
    logic [AW-1:0]       in_col_idx;
    logic [KIND_W-1:0]   r_kind;
    logic                r_inside;
    logic [AW-1:0]       r_row_idx;
    logic [AW-1:0]       r_col_idx;
    logic                r_cell_value;
    logic [GRID_MAX-1:0] r_win0;
    logic [GRID_MAX-1:0] r_win1;
    logic [GRID_MAX-1:0] next_row;
    logic [GRID_MAX-1:0] new_row;
    logic [GRID_MAX-1:0] merged_row;
    logic [GRID_MAX-1:0] col_mask;
    logic [GRID_MAX-1:0] rd_data;
    logic [AW-1:0]       rd_addr;
    logic                wr_en;
    logic [AW-1:0]       wr_addr;
    logic [GRID_MAX-1:0] wr_data;
    logic                r_res_alive;
    logic                r_res_done;
    logic                r_out_valid;
    logic                r_out_alive;
    logic                r_out_done;

    // size in use, capped at the store size
    assign w_size = (r_grid_size > SIZE_W'(NCAP)) ? SIZE_W'(NCAP) : r_grid_size;

    // sweep position relative to the size in use
    assign size_ext    = (RW+1)'(w_size);
    assign row_plus1   = {1'b0, r_row} + (RW+1)'(1);
    assign row_plus2   = {1'b0, r_row} + (RW+1)'(2);
    assign next_in_use = row_plus1 < size_ext;

    // address check of the incoming item
    assign in_inside  = (SIZE_W'(i_row) < w_size) && (SIZE_W'(i_col) < w_size);
    assign in_row_idx = in_inside ? AW'(i_row) : '0;
    assign in_col_idx = in_inside ? AW'(i_col) : '0;

    // status toward the controller
    assign o_status.in_valid   = i_in_valid;
    assign o_status.in_kind    = i_kind;
    assign o_status.size_zero  = (w_size == '0);
    assign o_status.clear_last = (r_row == RW'(GRID_MAX - 1));
    assign o_status.adv_last   = (row_plus1 == size_ext);
    assign o_status.out_free   = !r_out_valid || i_out_ready;

    // read address select
    always_comb begin
        rd_addr = '0;
        if (i_cmd.accept && (i_kind == KIND_WRITE || i_kind == KIND_READ)) begin
            rd_addr = in_row_idx;
        end else if (i_cmd.adv_load && ((RW+1)'(1) < size_ext)) begin
            rd_addr = AW'(1);
        end else if (i_cmd.adv_step && (row_plus2 < size_ext)) begin
            rd_addr = AW'(row_plus2);
        end
    end

    // row below the one being computed, dead past the last row in use
    assign next_row = next_in_use ? rd_data : '0;

    // per-column lanes: mask, neighbor count and B3/S23 rule
    always_comb begin
        logic [GRID_MAX-1:0] a;
        logic [GRID_MAX-1:0] b;
        logic [GRID_MAX-1:0] d;
        logic [3:0]          cnt;
        for (int c = 0; c < GRID_MAX; c++) begin
            col_mask[c] = (c < int'(w_size));
        end
        a   = r_win0 & col_mask;
        b   = r_win1 & col_mask;
        d   = next_row & col_mask;
        cnt = '0;
        for (int c = 0; c < GRID_MAX; c++) begin
            cnt = 4'(b[c+1 < GRID_MAX ? c+1 : c] & (c+1 < GRID_MAX))
                + 4'(a[c]) + 4'(d[c]);
            if (c > 0) begin
                cnt = cnt + 4'(a[c-1]) + 4'(b[c-1]) + 4'(d[c-1]);
            end
            if (c + 1 < GRID_MAX) begin
                cnt = cnt + 4'(a[c+1]) + 4'(d[c+1]);
            end
            if (col_mask[c]) begin
                new_row[c] = (cnt == BORN_COUNT) || ((cnt == KEEP_COUNT) && r_win1[c]);
            end else begin
                new_row[c] = r_win1[c];
            end
        end
    end

    // single-cell write merged into the stored row
    always_comb begin
        for (int c = 0; c < GRID_MAX; c++) begin
            merged_row[c] = (AW'(c) == r_col_idx) ? r_cell_value : rd_data[c];
        end
    end

    // write port select
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = '0;
        wr_data = '0;
        if (i_cmd.clear_wr) begin
            wr_en   = 1'b1;
            wr_addr = AW'(r_row);
        end else if (i_cmd.cell_op && (r_kind == KIND_WRITE) && r_inside) begin
            wr_en   = 1'b1;
            wr_addr = r_row_idx;
            wr_data = merged_row;
        end else if (i_cmd.adv_step) begin
            wr_en   = 1'b1;
            wr_addr = AW'(r_row);
            wr_data = new_row;
        end
    end

    // cell store, one row word per entry
    lge_ram #(
        .WIDTH (GRID_MAX),
        .DEPTH (GRID_MAX)
    ) u_cells (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    // control registers: size, row counter, output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_size <= SIZE_RESET;
            r_row       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_grid_size <= i_cfg_grid_size;
            end
            if (i_cmd.adv_load) begin
                r_row <= '0;
            end else if (i_cmd.clear_wr || i_cmd.adv_step) begin
                r_row <= r_row + RW'(1);
            end
            if (i_cmd.finish) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // item fields, window rows and results
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_kind       <= i_kind;
            r_inside     <= in_inside;
            r_row_idx    <= in_row_idx;
            r_col_idx    <= in_col_idx;
            r_cell_value <= i_cell_value;
            r_res_alive  <= 1'b0;
            r_res_done   <= (i_kind != KIND_UNUSED);
        end
        if (i_cmd.cell_op) begin
            r_res_alive <= (r_kind == KIND_READ) && r_inside && rd_data[r_col_idx];
        end
        if (i_cmd.adv_load) begin
            r_win0 <= '0;
            r_win1 <= rd_data;
        end else if (i_cmd.adv_step) begin
            r_win0 <= r_win1;
            r_win1 <= next_row;
        end
        if (i_cmd.finish) begin
            r_out_alive <= r_res_alive;
            r_out_done  <= r_res_done;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_cell_alive = r_out_alive;
    assign o_done_res   = r_out_done;
endmodule

/* hdl/life_generation_engine.sv */
// ----------------------------------------------------------------------------
// life_generation_engine
// B3/S23 cellular automaton on a square grid ringed by dead cells, with
// single-cell write and read and a whole-grid generation step.
// ----------------------------------------------------------------------------
//  channel   direction  carries
//  i_in      sink       kind, row, col, cell_value
//  o_out     source     cell_alive, done_res
//  i_cfg     sink       grid_size (always ready)
//
//  Write and read pass a cell access step before the result; the unused kind does not.
//  An advance loads the window, then writes back each row in use (none when no
//  row is in use): one row word goes through the single store write port per cycle.
//  After reset a clearing pass writes GRID_MAX rows, one per cycle, with
//  i_in.ready low; configuration writes are taken throughout.
//  A waiting result holds the next item's result in the block, not intake.
// ----------------------------------------------------------------------------
module life_generation_engine #(
    parameter int unsigned GRID_MAX = 64
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    lge_in_if.sink    i_in,
    lge_out_if.source o_out,
    lge_cfg_if.sink   i_cfg
);
    import lge_pkg::*;

    t_dp_cmd    cmd;
    t_dp_status status;
    logic       in_ready;

    // configuration is taken at any time
    assign i_cfg.ready = 1'b1;
    assign i_in.ready  = in_ready;

    // sequencer
    lge_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_status   (status),
        .o_cmd      (cmd),
        .o_in_ready (in_ready)
    );

    // store and generation logic
    lge_dp #(
        .GRID_MAX (GRID_MAX)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_status        (status),
        .i_in_valid      (i_in.valid),
        .i_kind          (i_in.kind),
        .i_row           (i_in.row),
        .i_col           (i_in.col),
        .i_cell_value    (i_in.cell_value),
        .i_cfg_valid     (i_cfg.valid),
        .i_cfg_grid_size (i_cfg.grid_size),
        .i_out_ready     (o_out.ready),
        .o_out_valid     (o_out.valid),
        .o_cell_alive    (o_out.cell_alive),
        .o_done_res      (o_out.done_res)
    );
endmodule

/* hdl/lge_checker.sv */
// ----------------------------------------------------------------------------
// lge_checker
// Port-level checks on the engine's handshakes and results, bound to the
// top level.
// ----------------------------------------------------------------------------
module lge_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_valid,
    input logic i_in_ready,
    input logic i_out_valid,
    input logic i_out_ready,
    input logic i_cell_alive,
    input logic i_done_res
);
    // a held result stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result dropped while stalled");

    // a held result keeps its value
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> $stable(i_cell_alive) && $stable(i_done_res))
        else $error("result changed while stalled");

    // one item at a time: intake closes right after an item is taken
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("second item taken while one is in work");

    // an error result never reports a live cell
    a_err_dead: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_done_res |-> !i_cell_alive)
        else $error("error result with cell_alive set");

    // reset starts the clearing pass with no result pending
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_in_ready && !i_out_valid)
        else $error("intake open or result pending after reset");
endmodule

bind life_generation_engine lge_checker u_lge_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in.valid),
    .i_in_ready   (i_in.ready),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_cell_alive (o_out.cell_alive),
    .i_done_res   (o_out.done_res)
);
